FILE: design/tksi_pkg.sv
// ----------------------------------------------------------------------------
// tksi_pkg
// Shared types, codes and helpers for the sorted top-k insertion table.
// ----------------------------------------------------------------------------
package tksi_pkg;

  // Transaction kinds on the request channel
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Request transaction
  typedef struct packed {
    logic        kind;
    logic [14:0] score;
    logic [7:0]  tag_byte_0;
    logic [7:0]  tag_byte_1;
    logic [7:0]  tag_byte_2;
    logic [3:0]  read_index;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic        accepted;
    logic [3:0]  slot;
    logic [4:0]  entry_count;
    logic        entry_valid;
    logic [14:0] entry_score;
    logic [7:0]  entry_tag_0;
    logic [7:0]  entry_tag_1;
    logic [7:0]  entry_tag_2;
  } rsp_t;

  // One stored table entry, tag byte 0 in the low bits of the tag
  typedef struct packed {
    logic [23:0] tag;
    logic [14:0] score;
  } entry_t;

  // Pack the tag; every byte after the first zero byte is forced to zero
  function automatic logic [23:0] pack_tag(logic [7:0] b0, logic [7:0] b1,
                                           logic [7:0] b2);
    logic [7:0] t1;
    logic [7:0] t2;
    t1 = (b0 == 8'd0) ? 8'd0 : b1;
    t2 = (t1 == 8'd0) ? 8'd0 : b2;
    return {t2, t1, b0};
  endfunction

endpackage

FILE: design/tksi_if.sv
// ----------------------------------------------------------------------------
// tksi_if
// Valid/ready channel interfaces for requests and responses.
// ----------------------------------------------------------------------------
interface tksi_req_if import tksi_pkg::*;;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tksi_rsp_if import tksi_pkg::*;;
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/tksi_ram.sv
// ----------------------------------------------------------------------------
// tksi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tksi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/top_k_sorted_insert_table.sv
// ----------------------------------------------------------------------------
// top_k_sorted_insert_table
// Table of up to CAPACITY entries kept sorted by descending score, with
// insert and indexed read transactions.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+------------------------------------------
//   req     | in  | valid / ready | kind, score, tag_byte_0..2, read_index
//   rsp     | out | valid / ready | accepted, slot, entry_count, entry_*
//
// One transaction at a time; req.ready is high only when the block is idle.
// A read passes S_READ then S_RESP (straight to S_RESP when past the stored
// entries). An insert scans in S_SCAN, unless the table is empty, then S_PUT
// when it lands in slot 0, then hands off in S_RESP; it compares n stored
// entries, at most CAPACITY, one compare per cycle against the single RAM
// read port while the shifted entry is written back.
// Synchronous reset empties the table; RAM contents are not cleared.
// The response is held in an output register until rsp.ready.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_table import tksi_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic         clk,
  input logic         rst,
  tksi_req_if.sink    req,
  tksi_rsp_if.source  rsp
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PUT,
    S_READ,
    S_RESP
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pos;
  req_t             item;
  rsp_t             rsp_data;
  logic             rsp_valid;

  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  entry_t           ram_wr_data;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;
  entry_t           ram_rd_data;

  logic             full;
  logic             gt;
  logic             at_end;
  logic [CNT_W-1:0] count_next;
  entry_t           new_entry;
  logic             req_fire;

  assign req.ready  = (state == S_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign rsp.valid  = rsp_valid;
  assign rsp.data   = rsp_data;

  assign full       = (count == CNT_W'(CAPACITY));
  assign count_next = full ? count : count + CNT_W'(1);
  assign gt         = (item.score > ram_rd_data.score);
  assign at_end     = (pos == CNT_W'(CAPACITY));
  assign new_entry  = '{tag: pack_tag(item.tag_byte_0, item.tag_byte_1, item.tag_byte_2),
                        score: item.score};

  // Entry store
  tksi_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // RAM port control: read ahead one slot while shifting the compared one
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = AW'(pos);
    ram_wr_data = ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          ram_rd_en = 1'b1;
          if (req.data.kind == KIND_READ) begin
            ram_rd_addr = AW'(req.data.read_index);
          end else begin
            ram_rd_addr = AW'(count - CNT_W'(1));
          end
        end
      end
      S_SCAN: begin
        if (gt) begin
          // shift compared entry down; the last one drops off a full table
          ram_wr_en = !at_end;
          if (pos > CNT_W'(1)) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(pos - CNT_W'(2));
          end
        end else if (!at_end) begin
          ram_wr_en   = 1'b1;
          ram_wr_data = new_entry;
        end
      end
      S_PUT: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = new_entry;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pos       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            item <= req.data;
            if (req.data.kind == KIND_READ) begin
              if (32'(req.data.read_index) < 32'(count)) begin
                state <= S_READ;
              end else begin
                rsp_data  <= '{entry_count: 5'(count), default: '0};
                rsp_valid <= 1'b1;
                state     <= S_RESP;
              end
            end else if (count == '0) begin
              pos   <= '0;
              state <= S_PUT;
            end else begin
              pos   <= count;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (gt) begin
            pos <= pos - CNT_W'(1);
            if (pos == CNT_W'(1)) begin
              state <= S_PUT;
            end
          end else if (at_end) begin
            // full table and score not above the last one
            rsp_data  <= '{entry_count: 5'(count), default: '0};
            rsp_valid <= 1'b1;
            state     <= S_RESP;
          end else begin
            count     <= count_next;
            rsp_data  <= '{accepted: 1'b1, slot: 4'(pos), entry_count: 5'(count_next),
                           default: '0};
            rsp_valid <= 1'b1;
            state     <= S_RESP;
          end
        end
        S_PUT: begin
          count     <= count_next;
          rsp_data  <= '{accepted: 1'b1, slot: 4'(pos), entry_count: 5'(count_next),
                         default: '0};
          rsp_valid <= 1'b1;
          state     <= S_RESP;
        end
        S_READ: begin
          rsp_data  <= '{entry_count: 5'(count),
                         entry_valid: 1'b1,
                         entry_score: ram_rd_data.score,
                         entry_tag_0: ram_rd_data.tag[7:0],
                         entry_tag_1: ram_rd_data.tag[15:8],
                         entry_tag_2: ram_rd_data.tag[23:16],
                         default: '0};
          rsp_valid <= 1'b1;
          state     <= S_RESP;
        end
        S_RESP: begin
          if (rsp.ready) begin
            rsp_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
